[rtl/snm_pkg.sv]
// Shared types and codes for the sigmoid neuron backpropagation unit.
`default_nettype none
package snm_pkg;

   localparam int ADDR_W = 11;

   localparam logic [2:0] MODE_WRITE  = 3'd0;
   localparam logic [2:0] MODE_FWD    = 3'd1;
   localparam logic [2:0] MODE_TARGET = 3'd2;
   localparam logic [2:0] MODE_HIDDEN = 3'd3;
   localparam logic [2:0] MODE_UPDATE = 3'd4;
   localparam logic [2:0] MODE_ERRT   = 3'd5;
   localparam logic [2:0] MODE_READ   = 3'd6;
   localparam logic [2:0] MODE_NONE   = 3'd7;

   localparam logic [1:0] KIND_OUTPUT = 2'd0;
   localparam logic [1:0] KIND_GRAD   = 2'd1;
   localparam logic [1:0] KIND_CHANGE = 2'd2;
   localparam logic [1:0] KIND_WEIGHT = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_COUNT = 2'd1;
   localparam logic [1:0] ERR_INDEX = 2'd2;

   localparam logic CSR_RATE   = 1'b0;
   localparam logic CSR_INPUTS = 1'b1;

   localparam logic [16:0] RATE_RESET   = 17'd6554;
   localparam logic [6:0]  INPUTS_RESET = 7'd64;

   typedef struct packed {
      logic [2:0]         mode;
      logic [6:0]         index;
      logic signed [31:0] value;
      logic signed [31:0] second_value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] result_value;
      logic [1:0]         error;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic [ADDR_W-1:0] wr_addr;
      logic              w_we;
      logic [31:0]       w_data;
      logic              s_we;
      logic [31:0]       s_data;
   } wst_req_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] w_rd;
      logic [31:0] s_rd;
   } wst_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_STEP2,
      ST_STEP3,
      ST_STEP4,
      ST_STEP5,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

[rtl/snm_sigmoid_rom.sv]
// Sigmoid lookup table built at elaboration, with a registered read.
`default_nettype none
module snm_sigmoid_rom #(
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] rom_addr,
   output logic [16:0]                   rom_data
);

   logic [16:0] tab [DEPTH];
   logic [16:0] rom_data_ff;

   function automatic logic [16:0] sig_val(input longint x);
      logic [63:0] a;
      logic [63:0] u;
      logic [63:0] u2;
      logic [63:0] u3;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] rem;
      logic [63:0] q;
      int          i;
      int          n;
      a = (x < 0) ? 64'(-x) : 64'(x);
      u = a << 8;
      u2 = (u * u) >> 32;
      u3 = (u2 * u) >> 32;
      e = (64'd1 << 32) - u + (u2 >> 1) - u3 / 64'd6;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      for (n = 0; n < 8; n++) e = (e * e) >> 32;
      d = (64'd1 << 32) + e;
      rem = '0;
      q = '0;
      for (i = 48; i >= 0; i--) begin
         rem = (rem << 1) | ((i == 48) ? 64'd1 : 64'd0);
         if (rem >= d) begin
            rem = rem - d;
            q[i] = 1'b1;
         end
      end
      return (x >= 0) ? 17'(q) : 17'(64'd65536 - q);
   endfunction

   for (genvar k = 0; k < DEPTH; k++) begin : g_tab
      localparam longint X = -64'sd524288 + (longint'(k) * 64'sd1048576) / DEPTH;
      localparam logic [16:0] V = sig_val(X);
      assign tab[k] = V;
   end

   always_ff @(posedge clock) begin
      rom_data_ff <= tab[rom_addr];
   end

   assign rom_data = rom_data_ff;

endmodule
`default_nettype wire

[rtl/snm_weight_store.sv]
// Weight and snapshot memories, with the snapshot clearing pass after reset.
`default_nettype none
module snm_weight_store
   import snm_pkg::*;
#(
   parameter int MAX_INPUTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire wst_req_type wst_req,
   output wst_rsp_type      wst_rsp
);

   localparam int DEPTH = MAX_INPUTS + 1;
   localparam int AW = $clog2(DEPTH);

   logic [31:0]   w_mem [DEPTH];
   logic [31:0]   s_mem [DEPTH];
   logic [31:0]   w_rd_ff;
   logic [31:0]   s_rd_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic          busy_ff;
   logic          busy_in;

   always_comb begin
      clr_in = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(DEPTH - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wst_req.w_we) w_mem[wst_req.wr_addr[AW-1:0]] <= wst_req.w_data;
      w_rd_ff <= w_mem[wst_req.rd_addr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         s_mem[clr_ff] <= '0;
      end else if (wst_req.s_we) begin
         s_mem[wst_req.wr_addr[AW-1:0]] <= wst_req.s_data;
      end
      s_rd_ff <= s_mem[wst_req.rd_addr[AW-1:0]];
   end

   assign wst_rsp.busy = busy_ff;
   assign wst_rsp.w_rd = w_rd_ff;
   assign wst_rsp.s_rd = s_rd_ff;

endmodule
`default_nettype wire

[rtl/sigmoid_neuron_backprop_unit.sv]
// Top level of the sigmoid neuron backpropagation unit: sequencer and datapath.
`default_nettype none
// One sigmoid neuron in Q16.16 whose weights sit in a synchronous memory with a registered
// read. Items are taken one at a time, and an item that gives a result reaches the output
// register (the final element of a forward or hidden run takes longest) after steps set by the
// memory read latency, the single shared 33x33 multiplier that the steps of an item take in
// turn, and the registered sigmoid table read. After reset all MAX_INPUTS+1 entries of the
// snapshot memory are cleared, and req_stall stays high while they are.
module sigmoid_neuron_backprop_unit
   import snm_pkg::*;
#(
   parameter int MAX_INPUTS = 64,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_data
);

   localparam int CW = $clog2(MAX_INPUTS + 2);
   localparam int TAW = $clog2(SIGMOID_TABLE_DEPTH);

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -66'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] out_ff, out_in;
   logic signed [31:0] grad_ff, grad_in;
   logic signed [31:0] sum_ff, sum_in;
   logic signed [31:0] whold_ff, whold_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [16:0]        rate_ff, rate_in;
   logic [6:0]         inuse_ff, inuse_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   rsp_type            res_ff, res_in;

   logic signed [32:0] mul_a, mul_b;
   wst_req_type        wst_req;
   wst_rsp_type        wst_rsp;
   logic [TAW-1:0]     rom_addr;
   logic [16:0]        rom_data;
   logic               accept;
   logic               out_free;
   logic               idx_ok;
   logic               req_idx_ok;
   logic               mismatch;
   logic [CW-1:0]      count_next;
   logic signed [65:0] prod_sh;
   logic signed [63:0] sq_clamp;
   logic signed [63:0] bias_sum;
   logic [19:0]        rom_off;
   logic [20+TAW:0]    rom_prod;

   snm_weight_store #(
      .MAX_INPUTS(MAX_INPUTS)
   ) u_store (
      .clock  (clock),
      .reset  (reset),
      .wst_req(wst_req),
      .wst_rsp(wst_rsp)
   );

   snm_sigmoid_rom #(
      .DEPTH(SIGMOID_TABLE_DEPTH)
   ) u_rom (
      .clock   (clock),
      .rom_addr(rom_addr),
      .rom_data(rom_data)
   );

   assign req_stall = (state_ff != ST_IDLE) || wst_rsp.busy;
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_ok = 32'(item_ff.index) <= 32'(MAX_INPUTS);
   assign req_idx_ok = 32'(req_data.index) <= 32'(MAX_INPUTS);
   assign mismatch = 32'(count_ff) != 32'(inuse_ff);
   assign count_next = (32'(count_ff) <= 32'(MAX_INPUTS)) ? count_ff + CW'(1) : count_ff;
   assign prod_sh = prod_ff >>> 16;
   assign sq_clamp = (prod_ff[65:63] != 3'b000) ? {1'b0, {63{1'b1}}} : prod_ff[63:0];
   assign bias_sum = sat_add64(acc_ff, 64'(signed'(wst_rsp.w_rd)) <<< 16);
   assign prod_in = mul_a * mul_b;
   assign rom_off = 20'(sum_ff + 32'sd524288);
   assign rom_prod = (20+TAW+1)'(rom_off) * (20+TAW+1)'(SIGMOID_TABLE_DEPTH);

   always_comb begin
      if (sum_ff < -32'sd524288) begin
         rom_addr = '0;
      end else if (sum_ff >= 32'sd524288) begin
         rom_addr = TAW'(SIGMOID_TABLE_DEPTH - 1);
      end else begin
         rom_addr = rom_prod[20 +: TAW];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.mode != MODE_NONE) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (item_ff.mode)
               MODE_WRITE:  state_in = idx_ok ? ST_IDLE : ST_EMIT;
               MODE_READ:   state_in = ST_EMIT;
               MODE_UPDATE: state_in = idx_ok ? ST_STEP2 : ST_EMIT;
               MODE_FWD, MODE_TARGET, MODE_HIDDEN, MODE_ERRT: state_in = ST_STEP2;
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_STEP2: begin
            case (item_ff.mode)
               MODE_TARGET, MODE_UPDATE: state_in = ST_STEP3;
               default: state_in = item_ff.last ? ST_STEP3 : ST_IDLE;
            endcase
         end
         ST_STEP3: begin
            case (item_ff.mode)
               MODE_FWD:    state_in = mismatch ? ST_EMIT : ST_STEP4;
               MODE_HIDDEN: state_in = ST_STEP4;
               MODE_UPDATE: state_in = ST_IDLE;
               default:     state_in = ST_EMIT;
            endcase
         end
         ST_STEP4: state_in = ST_STEP5;
         ST_STEP5: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      item_in = item_ff;
      acc_in = acc_ff;
      count_in = count_ff;
      out_in = out_ff;
      grad_in = grad_ff;
      sum_in = sum_ff;
      whold_in = whold_ff;
      res_in = res_ff;
      mul_a = '0;
      mul_b = '0;
      wst_req = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      rate_in = rate_ff;
      inuse_in = inuse_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RATE:   rate_in = csr_data;
            CSR_INPUTS: inuse_in = csr_data[6:0];
            default:    ;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.mode == MODE_FWD) begin
                  if (32'(count_ff) < 32'(MAX_INPUTS)) begin
                     wst_req.rd_addr = ADDR_W'(count_ff) + ADDR_W'(1);
                  end
               end else if (req_idx_ok) begin
                  wst_req.rd_addr = ADDR_W'(req_data.index);
               end
            end
         end
         ST_EXEC: begin
            res_in = '{kind: KIND_WEIGHT, result_value: '0, error: ERR_INDEX};
            whold_in = wst_rsp.w_rd;
            case (item_ff.mode)
               MODE_WRITE: begin
                  wst_req.wr_addr = ADDR_W'(item_ff.index);
                  wst_req.w_data = item_ff.value;
                  wst_req.w_we = idx_ok;
               end
               MODE_READ: begin
                  if (idx_ok) res_in = '{kind: KIND_WEIGHT, result_value: wst_rsp.w_rd,
                                         error: ERR_NONE};
               end
               MODE_FWD: begin
                  mul_a = 33'(item_ff.value);
                  mul_b = 33'(signed'(wst_rsp.w_rd));
               end
               MODE_TARGET: begin
                  mul_a = 33'(out_ff);
                  mul_b = 33'sd65536 - 33'(out_ff);
               end
               MODE_HIDDEN: begin
                  mul_a = 33'(item_ff.value);
                  mul_b = 33'(item_ff.second_value);
               end
               MODE_UPDATE: begin
                  mul_a = 33'(grad_ff);
                  mul_b = 33'(item_ff.value);
               end
               MODE_ERRT: begin
                  mul_a = 33'(signed'(wst_rsp.w_rd)) - 33'(signed'(wst_rsp.s_rd));
                  mul_b = mul_a;
                  wst_req.wr_addr = ADDR_W'(item_ff.index);
                  wst_req.s_data = wst_rsp.w_rd;
                  wst_req.s_we = idx_ok;
               end
               default: ;
            endcase
         end
         ST_STEP2: begin
            case (item_ff.mode)
               MODE_FWD: begin
                  if (32'(count_ff) < 32'(MAX_INPUTS)) acc_in = sat_add64(acc_ff, prod_ff[63:0]);
                  count_in = count_next;
               end
               MODE_HIDDEN: begin
                  acc_in = sat_add64(acc_ff, prod_ff[63:0]);
                  count_in = count_next;
               end
               MODE_ERRT: begin
                  if (idx_ok) acc_in = sat_add64(acc_ff, sq_clamp);
                  count_in = count_next;
               end
               MODE_TARGET: begin
                  mul_a = 33'(item_ff.value) - 33'(out_ff);
                  mul_b = prod_sh[32:0];
               end
               MODE_UPDATE: begin
                  mul_a = (item_ff.index == '0) ? 33'(grad_ff) : 33'(sat32(prod_sh));
                  mul_b = 33'(rate_ff);
               end
               default: ;
            endcase
         end
         ST_STEP3: begin
            case (item_ff.mode)
               MODE_FWD: begin
                  res_in = '{kind: KIND_OUTPUT, result_value: '0, error: ERR_COUNT};
                  sum_in = sat32(66'(bias_sum) >>> 16);
                  acc_in = '0;
                  count_in = '0;
               end
               MODE_TARGET: begin
                  grad_in = sat32(prod_sh);
                  res_in = '{kind: KIND_GRAD, result_value: sat32(prod_sh), error: ERR_NONE};
               end
               MODE_HIDDEN: begin
                  mul_a = 33'(out_ff);
                  mul_b = 33'sd65536 - 33'(out_ff);
               end
               MODE_UPDATE: begin
                  wst_req.wr_addr = ADDR_W'(item_ff.index);
                  wst_req.w_data = sat32(66'(whold_ff) + prod_sh);
                  wst_req.w_we = 1'b1;
               end
               MODE_ERRT: begin
                  res_in = '{kind: KIND_CHANGE, result_value: sat32(66'(acc_ff) >>> 16),
                             error: ERR_NONE};
                  acc_in = '0;
                  count_in = '0;
               end
               default: ;
            endcase
         end
         ST_STEP4: begin
            if (item_ff.mode == MODE_HIDDEN) begin
               mul_a = prod_sh[32:0];
               mul_b = 33'(sat32(66'(acc_ff) >>> 16));
            end
         end
         ST_STEP5: begin
            if (item_ff.mode == MODE_HIDDEN) begin
               grad_in = sat32(prod_sh);
               res_in = '{kind: KIND_GRAD, result_value: sat32(prod_sh), error: ERR_NONE};
               acc_in = '0;
               count_in = '0;
            end else begin
               out_in = 32'(rom_data);
               res_in = '{kind: KIND_OUTPUT, result_value: 32'(rom_data), error: ERR_NONE};
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff <= '0;
         count_ff <= '0;
         out_ff <= '0;
         grad_ff <= '0;
         rate_ff <= RATE_RESET;
         inuse_ff <= INPUTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         out_ff <= out_in;
         grad_ff <= grad_in;
         rate_ff <= rate_in;
         inuse_ff <= inuse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sum_ff <= sum_in;
      whold_ff <= whold_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule
`default_nettype wire

[rtl/snm_checker.sv]
// Port-level checks for the sigmoid neuron backpropagation unit, bound to its top level.
`default_nettype none
module snm_checker
   import snm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rsp_type     rsp_data,
   input wire logic        csr_we,
   input wire logic        csr_index,
   input wire logic [16:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error != ERR_NONE |-> rsp_data.result_value == '0)
      else $error("Error beat carries a nonzero value.");

   a_count_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error == ERR_COUNT |-> rsp_data.kind == KIND_OUTPUT)
      else $error("Count mismatch reported on a non-output beat.");

   a_sig_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_OUTPUT && rsp_data.error == ERR_NONE
      |-> rsp_data.result_value >= 0 && rsp_data.result_value <= 32'sd65536)
      else $error("Neuron output outside the sigmoid range.");

   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("Input taken during the clearing pass.");

endmodule

bind sigmoid_neuron_backprop_unit snm_checker u_snm_checker (.*);
`default_nettype wire

[test/tb_sigmoid_neuron_backprop_unit.sv]
// Self-checking testbench for the sigmoid neuron backpropagation unit.
`timescale 1ns / 100ps

module tb_sigmoid_neuron_backprop_unit;
   import snm_pkg::*;

   localparam int NW = 65;
   localparam int ROM_DEPTH = 1024;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 16;
   localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint SMIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

   class neuron_scoreboard;
      int weight_mem[NW];
      int snap_mem[NW];
      longint acc;
      int run_len;
      int out_q;
      int grad_q;
      int rate_q;
      int inputs_q;
      int sig_rom[ROM_DEPTH];
      rsp_type pending_q[$];
      int errors;
      int seen[4];

      function new();
         for (int k = 0; k < ROM_DEPTH; k++) begin
            longint x;
            bit [63:0] a, u, u2, u3, e, s;
            x = -524288 + (longint'(k) * 1048576) / ROM_DEPTH;
            a = (x < 0) ? -x : x;
            u = a << 8;
            u2 = (u * u) >> 32;
            u3 = (u2 * u) >> 32;
            e = 64'h1_0000_0000 - u + (u2 >> 1) - u3 / 6;
            if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
            repeat (8) e = (e * e) >> 32;
            s = (64'h1 << 48) / (64'h1_0000_0000 + e);
            sig_rom[k] = (x >= 0) ? int'(s) : 65536 - int'(s);
         end
         for (int i = 0; i < NW; i++) begin
            weight_mem[i] = 0;
            snap_mem[i] = 0;
         end
         acc = 0;
         run_len = 0;
         out_q = 0;
         grad_q = 0;
         rate_q = RATE_RESET;
         inputs_q = INPUTS_RESET;
         errors = 0;
      endfunction

      function int sat32(longint v);
         if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
         if (v < -64'sd2147483648) return 32'h8000_0000;
         return int'(v);
      endfunction

      function longint sadd(longint a, longint b);
         if (b > 0 && a > SMAX - b) return SMAX;
         if (b < 0 && a < SMIN - b) return SMIN;
         return a + b;
      endfunction

      function longint slope();
         longint o;
         o = out_q;
         return (o * (65536 - o)) >>> 16;
      endfunction

      function int sigmoid(longint s);
         if (s < -524288) return sig_rom[0];
         if (s >= 524288) return sig_rom[ROM_DEPTH-1];
         return sig_rom[((s + 524288) * ROM_DEPTH) >>> 20];
      endfunction

      function void set_csr(logic idx, int val);
         if (idx == CSR_RATE) rate_q = val & 32'h1FFFF;
         else inputs_q = val & 32'h7F;
      endfunction

      function void note(req_type r);
         int v, v2;
         longint m, d, c, sq;
         bit [63:0] ac, usq;
         bit ok, emit;
         rsp_type e;
         v = $signed(r.value);
         v2 = $signed(r.second_value);
         ok = r.index <= MAX_IDX();
         emit = 1'b0;
         e = '0;
         case (r.mode)
            MODE_WRITE: begin
               if (ok) weight_mem[r.index] = v;
               else begin
                  emit = 1'b1;
                  e.kind = KIND_WEIGHT;
                  e.error = ERR_INDEX;
               end
            end
            MODE_FWD: begin
               if (run_len < 64) acc = sadd(acc, longint'(v) * weight_mem[run_len+1]);
               if (run_len <= 64) run_len++;
               if (r.last) begin
                  emit = 1'b1;
                  e.kind = KIND_OUTPUT;
                  if (run_len != inputs_q) e.error = ERR_COUNT;
                  else begin
                     out_q = sigmoid(sat32(sadd(acc, longint'(weight_mem[0]) * 65536) >>> 16));
                     e.result_value = out_q;
                  end
                  acc = 0;
                  run_len = 0;
               end
            end
            MODE_TARGET: begin
               grad_q = sat32(((longint'(v) - out_q) * slope()) >>> 16);
               emit = 1'b1;
               e.kind = KIND_GRAD;
               e.result_value = grad_q;
            end
            MODE_HIDDEN: begin
               acc = sadd(acc, longint'(v) * v2);
               if (run_len <= 64) run_len++;
               if (r.last) begin
                  grad_q = sat32((slope() * sat32(acc >>> 16)) >>> 16);
                  emit = 1'b1;
                  e.kind = KIND_GRAD;
                  e.result_value = grad_q;
                  acc = 0;
                  run_len = 0;
               end
            end
            MODE_UPDATE: begin
               if (ok) begin
                  m = (r.index == 0) ? longint'(grad_q) : sat32((longint'(grad_q) * v) >>> 16);
                  d = (m * rate_q) >>> 16;
                  weight_mem[r.index] = sat32(longint'(weight_mem[r.index]) + d);
               end else begin
                  emit = 1'b1;
                  e.kind = KIND_WEIGHT;
                  e.error = ERR_INDEX;
               end
            end
            MODE_ERRT: begin
               if (ok) begin
                  c = longint'(weight_mem[r.index]) - snap_mem[r.index];
                  ac = (c < 0) ? -c : c;
                  if (ac >= 64'h1_0000_0000) sq = SMAX;
                  else begin
                     usq = ac * ac;
                     sq = (usq > 64'h7FFF_FFFF_FFFF_FFFF) ? SMAX : longint'(usq);
                  end
                  acc = sadd(acc, sq);
                  snap_mem[r.index] = weight_mem[r.index];
               end
               if (run_len <= 64) run_len++;
               if (r.last) begin
                  emit = 1'b1;
                  e.kind = KIND_CHANGE;
                  e.result_value = sat32(acc >>> 16);
                  acc = 0;
                  run_len = 0;
               end
            end
            MODE_READ: begin
               emit = 1'b1;
               e.kind = KIND_WEIGHT;
               if (ok) e.result_value = weight_mem[r.index];
               else e.error = ERR_INDEX;
            end
            default: ;
         endcase
         if (emit) pending_q.insert(pending_q.size(), e);
      endfunction

      function int MAX_IDX();
         return NW - 1;
      endfunction

      function void check(rsp_type a);
         rsp_type e;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: kind %0d value %0d error %0d", $time,
                     a.kind, a.result_value, a.error);
            return;
         end
         e = pending_q.pop_front();
         seen[a.kind]++;
         if (a.kind !== e.kind) begin
            errors++;
            $display("%0t kind mismatch: expected %0d actual %0d", $time, e.kind, a.kind);
         end
         if (a.result_value !== e.result_value) begin
            errors++;
            $display("%0t value mismatch: expected %0d actual %0d", $time,
                     e.result_value, a.result_value);
         end
         if (a.error !== e.error) begin
            errors++;
            $display("%0t error mismatch: expected %0d actual %0d", $time, e.error, a.error);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_RATE;
   logic [16:0] csr_data = '0;

   neuron_scoreboard sb = new();
   int cycles = 0;
   int n_sent = 0;
   int burst_left = 0;
   int cur_inputs = INPUTS_RESET;
   bit hold_req = 1'b0;
   int hold_cnt = 0;
   int pat = 0;
   int pat_left = 0;

   sigmoid_neuron_backprop_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
      if (!reset && req_valid && !req_stall) sb.note(req_data);
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
   end

   always @(posedge clock) begin
      if (hold_req && hold_cnt == 0) begin
         hold_cnt = 400;
         hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         if (pat_left == 0) begin
            pat = $urandom_range(0, 2);
            pat_left = $urandom_range(20, 200);
         end
         pat_left--;
         case (pat)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic int rnd_val();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return int'($urandom_range(0, 32'h80000)) - 32'h40000;
      if (r < 8) return int'($urandom_range(0, 32'h20000)) - 32'h10000;
      return int'($urandom);
   endfunction

   function automatic logic [6:0] rnd_index(int bad_pct);
      if ($urandom_range(0, 99) < bad_pct) return 7'($urandom_range(NW, 127));
      return 7'($urandom_range(0, NW - 1));
   endfunction

   function automatic req_type mk(logic [2:0] mode, logic [6:0] idx, int v, int v2, logic last);
      req_type r;
      r.mode = mode;
      r.index = idx;
      r.value = v;
      r.second_value = v2;
      r.last = last;
      return r;
   endfunction

   task automatic send(req_type it);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      if (it.mode != MODE_NONE) n_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= 17'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_csr(idx, val);
      if (idx == CSR_INPUTS) cur_inputs = val;
   endtask

   task automatic send_run(logic [2:0] mode, int len);
      for (int i = 0; i < len; i++)
         send(mk(mode, (mode == MODE_ERRT) ? rnd_index(10) : rnd_index(5), rnd_val(),
                 rnd_val(), i == len - 1));
   endtask

   task automatic random_items(int n);
      int stop_at, r, len;
      stop_at = n_sent + n;
      while (n_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            len = cur_inputs;
            if ($urandom_range(0, 4) == 0) len = len + (($urandom_range(0, 1) == 0) ? 1 : -1);
            if (len < 1) len = 1;
            send_run(MODE_FWD, len);
         end else if (r < 35) send_run(MODE_HIDDEN, $urandom_range(1, 6));
         else if (r < 45) send_run(MODE_ERRT, $urandom_range(1, 5));
         else if (r < 55) send(mk(MODE_TARGET, 7'($urandom), rnd_val(), rnd_val(), 1'($urandom)));
         else if (r < 70) send(mk(MODE_UPDATE, rnd_index(5), rnd_val(), rnd_val(), 1'($urandom)));
         else if (r < 80) send(mk(MODE_WRITE, rnd_index(5), rnd_val(), rnd_val(), 1'($urandom)));
         else if (r < 90) send(mk(MODE_READ, rnd_index(8), rnd_val(), rnd_val(), 1'($urandom)));
         else if (r < 97) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               send(mk(($urandom_range(0, 2) == 0) ? MODE_FWD :
                       (($urandom_range(0, 1) == 0) ? MODE_HIDDEN : MODE_ERRT),
                       rnd_index(10), rnd_val(), rnd_val(), 1'($urandom)));
         end else send(mk(MODE_NONE, 7'($urandom), rnd_val(), rnd_val(), 1'($urandom)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_RATE, RATE_RESET);
      write_csr(CSR_INPUTS, 3);
      for (int i = 0; i < NW; i++)
         send(mk(MODE_WRITE, 7'(i), int'($urandom_range(0, 32'h20000)) - 32'h10000, 0, 1'b0));

      send(mk(MODE_WRITE, 7'd0, 32'h8000_0000, 0, 1'b0));
      send(mk(MODE_WRITE, 7'd64, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send(mk(MODE_READ, 7'd64, 0, 0, 1'b0));
      send(mk(MODE_READ, 7'd0, 0, 0, 1'b0));
      send(mk(MODE_WRITE, 7'd65, 32'h1234_5678, 0, 1'b0));
      send(mk(MODE_READ, 7'd127, 0, 0, 1'b0));
      send(mk(MODE_UPDATE, 7'd100, 32'h10000, 0, 1'b0));
      send(mk(MODE_ERRT, 7'd127, 0, 0, 1'b0));
      send(mk(MODE_NONE, 7'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send(mk(MODE_WRITE, 7'd0, 32'h10000, 0, 1'b0));
      send(mk(MODE_FWD, 7'd0, 32'h7FFF_FFFF, 0, 1'b0));
      send(mk(MODE_FWD, 7'd0, 32'h8000_0000, 0, 1'b0));
      send(mk(MODE_FWD, 7'd0, 0, 0, 1'b1));
      send(mk(MODE_TARGET, 7'd0, 32'h7FFF_FFFF, 0, 1'b0));
      send(mk(MODE_TARGET, 7'd0, 32'h8000_0000, 0, 1'b0));
      send(mk(MODE_FWD, 7'd0, 32'h10000, 0, 1'b0));
      send(mk(MODE_FWD, 7'd0, 32'h10000, 0, 1'b1));
      send(mk(MODE_HIDDEN, 7'd0, 32'h8000_0000, 32'h8000_0000, 1'b0));
      send(mk(MODE_HIDDEN, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
      send(mk(MODE_UPDATE, 7'd0, 32'h10000, 0, 1'b0));
      send(mk(MODE_UPDATE, 7'd64, 32'h7FFF_FFFF, 0, 1'b0));
      send(mk(MODE_ERRT, 7'd0, 0, 0, 1'b0));
      send(mk(MODE_ERRT, 7'd64, 0, 0, 1'b1));
      random_items(120);
      drain();

      write_csr(CSR_RATE, 65536);
      write_csr(CSR_INPUTS, 1);
      random_items(200);
      drain();

      write_csr(CSR_RATE, 0);
      write_csr(CSR_INPUTS, 64);
      hold_req = 1'b1;
      random_items(150);
      drain();

      write_csr(CSR_RATE, $urandom_range(0, 65536));
      write_csr(CSR_INPUTS, $urandom_range(1, 8));
      random_items(250);
      drain();

      write_csr(CSR_RATE, $urandom_range(0, 65536));
      write_csr(CSR_INPUTS, $urandom_range(1, 64));
      random_items(200);
      drain();

      $display("Accepted %0d request beats over five rate and input-count settings.", n_sent);
      $display("Checked outputs %0d, gradients %0d, weight changes %0d, reads/errors %0d.",
               sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
      if (sb.errors == 0 && sb.pending_q.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
